### rtl/lz77te_pkg.sv
// lz77te_pkg: shared constants and types of the lz77 token encoder
// no dependencies; imported by every rtl file of the block
package lz77te_pkg;

  localparam int MAX_MATCH         = 15;
  localparam int LA_DEPTH          = MAX_MATCH + 1;
  localparam int LA_IDX_W          = $clog2(LA_DEPTH);
  localparam int LA_CNT_W          = $clog2(LA_DEPTH + 1);
  localparam int LEN_W             = 4;
  localparam int DIST_W            = 10;
  localparam int CFG_W             = 10;
  localparam int BYTE_W            = 8;
  localparam int DEF_HISTORY_DEPTH = 512;
  localparam int DEF_RING_DEPTH    = 1024;

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(512);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_e;

endpackage

### rtl/lz77te_ring_ram.sv
// lz77te_ring_ram: byte history ring, one write port and one registered read port
// depends on lz77te_pkg
module lz77te_ring_ram
  import lz77te_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int RW         = $clog2(RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [RW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic [RW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [RING_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lz77_token_encoder_top.sv
// lz77_token_encoder_top: greedy lz77 tokenizer with window search over the ring
// depends on lz77te_pkg and lz77te_ring_ram
//
// usage: bytes enter on the input channel (in_valid_i/in_ready_o), one per
// transfer, with end_of_data_i on the final byte of a text. tokens leave on
// the output channel (out_valid_o/out_ready_i) through an output register.
// a token is produced once 16 bytes of lookahead are held; a byte with
// end_of_data_i flushes all remaining tokens, the last one with last_token_o.
// a token search steps through init, a read and a compare for each compared
// byte, and emit: each window candidate compares its bytes through the one
// read port of the ring, up to 15 per candidate, and the search over
// min(window, history) candidates stops early on a full match.
// no input is taken while tokens are being searched or flushed.
// users write window_size by cfg_we_i only while idle, not enforced; it resets to 512.
// at reset the pointers, counts and output valid clear; ring contents are
// not cleared, only bytes of the current text are ever read.
// when out_ready_i is low the finished token waits in the output register
// and the next token search holds at its end until the register frees.
module lz77_token_encoder_top
  import lz77te_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int RING_DEPTH    = DEF_RING_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              end_of_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DIST_W-1:0] match_distance_o,
  output logic [LEN_W-1:0]  match_length_o,
  output logic [BYTE_W-1:0] literal_byte_o,
  output logic              next_is_end_o,
  output logic              last_token_o
);

  localparam int RW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = (FW > CFG_W) ? FW : CFG_W;

  function automatic logic [RW-1:0] ptr_inc(input logic [RW-1:0] p);
    return (p == RW'(RING_DEPTH - 1)) ? '0 : p + RW'(1);
  endfunction

  function automatic logic [RW-1:0] ptr_dec(input logic [RW-1:0] p);
    return (p == '0) ? RW'(RING_DEPTH - 1) : p - RW'(1);
  endfunction

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    window_q, window_d;
  logic [RW-1:0]       wr_q, wr_d;
  logic [RW-1:0]       cur_q, cur_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [LA_CNT_W-1:0] la_cnt_q, la_cnt_d;
  logic [BYTE_W-1:0]   la_q [LA_DEPTH];
  logic [BYTE_W-1:0]   la_d [LA_DEPTH];
  logic                flush_q, flush_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [LEN_W-1:0]    best_len_q, best_len_d;
  logic [DIST_W-1:0]   best_dist_q, best_dist_d;
  logic [RW-1:0]       base_q, base_d;
  logic [RW-1:0]       rptr_q, rptr_d;

  logic                out_valid_q, out_valid_d;
  logic [DIST_W-1:0]   out_dist_q, out_dist_d;
  logic [LEN_W-1:0]    out_len_q, out_len_d;
  logic [BYTE_W-1:0]   out_lit_q, out_lit_d;
  logic                out_end_q, out_end_d;
  logic                out_last_q, out_last_d;

  logic                in_xfer;
  logic [BYTE_W-1:0]   rdata;
  logic [SW-1:0]       win_ext, span_ext;
  logic [DIST_W-1:0]   span;
  logic [LEN_W-1:0]    limit;
  logic                hit;
  logic [LEN_W-1:0]    cand_len;
  logic                at_end;
  logic [LA_CNT_W-1:0] used;
  logic [LA_CNT_W-1:0] la_left;
  logic [RW:0]         cur_sum;
  logic [SW:0]         fill_sum;
  logic                emit_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  lz77te_ring_ram #(
    .RING_DEPTH(RING_DEPTH),
    .RW        (RW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (in_xfer),
    .waddr_i(wr_q),
    .wdata_i(data_byte_i),
    .raddr_i(rptr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    win_ext  = (SW'(window_q) > SW'(HISTORY_DEPTH)) ? SW'(HISTORY_DEPTH) : SW'(window_q);
    span_ext = (win_ext < SW'(fill_q)) ? win_ext : SW'(fill_q);
    span     = span_ext[DIST_W-1:0];
    limit    = (la_cnt_q < LA_CNT_W'(MAX_MATCH)) ? la_cnt_q[LEN_W-1:0] : LEN_W'(MAX_MATCH);
    hit      = (rdata == la_q[len_q]);
    cand_len = hit ? len_q + LEN_W'(1) : len_q;
    at_end   = (LA_CNT_W'(best_len_q) >= la_cnt_q);
    used     = at_end ? la_cnt_q : LA_CNT_W'(best_len_q) + LA_CNT_W'(1);
    la_left  = la_cnt_q - used;
    cur_sum  = (RW+1)'(cur_q) + (RW+1)'(used);
    fill_sum = (SW+1)'(fill_q) + (SW+1)'(used);
    emit_go  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    state_d     = state_q;
    window_d    = cfg_we_i ? cfg_wdata_i : window_q;
    wr_d        = wr_q;
    cur_d       = cur_q;
    fill_d      = fill_q;
    la_cnt_d    = la_cnt_q;
    la_d        = la_q;
    flush_d     = flush_q;
    dist_d      = dist_q;
    len_d       = len_q;
    best_len_d  = best_len_q;
    best_dist_d = best_dist_q;
    base_d      = base_q;
    rptr_d      = rptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dist_d  = out_dist_q;
    out_len_d   = out_len_q;
    out_lit_d   = out_lit_q;
    out_end_d   = out_end_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          wr_d                        = ptr_inc(wr_q);
          la_d[la_cnt_q[LA_IDX_W-1:0]] = data_byte_i;
          la_cnt_d                    = la_cnt_q + LA_CNT_W'(1);
          if (end_of_data_i) begin
            flush_d = 1'b1;
            state_d = ST_INIT;
          end else if (la_cnt_q == LA_CNT_W'(LA_DEPTH - 1)) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        dist_d      = DIST_W'(1);
        len_d       = '0;
        best_len_d  = '0;
        best_dist_d = '0;
        base_d      = ptr_dec(cur_q);
        rptr_d      = ptr_dec(cur_q);
        state_d     = (span == '0) ? ST_EMIT : ST_READ;
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (hit && (cand_len < limit)) begin
          len_d   = cand_len;
          rptr_d  = ptr_inc(rptr_q);
          state_d = ST_READ;
        end else begin
          if (cand_len > best_len_q) begin
            best_len_d  = cand_len;
            best_dist_d = dist_q;
          end
          if ((dist_q == span) || (cand_len == limit)) begin
            state_d = ST_EMIT;
          end else begin
            dist_d  = dist_q + DIST_W'(1);
            len_d   = '0;
            base_d  = ptr_dec(base_q);
            rptr_d  = ptr_dec(base_q);
            state_d = ST_READ;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_dist_d  = best_dist_q;
          out_len_d   = best_len_q;
          out_lit_d   = at_end ? '0 : la_q[best_len_q];
          out_end_d   = at_end;
          out_last_d  = flush_q && (la_left == '0);
          cur_d       = (cur_sum >= (RW+1)'(RING_DEPTH)) ?
                        RW'(cur_sum - (RW+1)'(RING_DEPTH)) : cur_sum[RW-1:0];
          la_cnt_d    = la_left;
          fill_d      = (fill_sum > (SW+1)'(HISTORY_DEPTH)) ?
                        FW'(HISTORY_DEPTH) : fill_sum[FW-1:0];
          for (int i = 0; i < LA_DEPTH; i++) begin
            if ((i + int'(used)) < LA_DEPTH) begin
              la_d[i] = la_q[LA_IDX_W'(i + int'(used))];
            end
          end
          if (flush_q && (la_left != '0)) begin
            state_d = ST_INIT;
          end else if (flush_q) begin
            fill_d  = '0;
            cur_d   = wr_q;
            flush_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RESET;
      wr_q        <= '0;
      cur_q       <= '0;
      fill_q      <= '0;
      la_cnt_q    <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      wr_q        <= wr_d;
      cur_q       <= cur_d;
      fill_q      <= fill_d;
      la_cnt_q    <= la_cnt_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la_q        <= la_d;
    dist_q      <= dist_d;
    len_q       <= len_d;
    best_len_q  <= best_len_d;
    best_dist_q <= best_dist_d;
    base_q      <= base_d;
    rptr_q      <= rptr_d;
    out_dist_q  <= out_dist_d;
    out_len_q   <= out_len_d;
    out_lit_q   <= out_lit_d;
    out_end_q   <= out_end_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign match_distance_o = out_dist_q;
  assign match_length_o   = out_len_q;
  assign literal_byte_o   = out_lit_q;
  assign next_is_end_o    = out_end_q;
  assign last_token_o     = out_last_q;

  // lookahead never overflows its registers
  a_la_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    la_cnt_q <= LA_CNT_W'(LA_DEPTH))
    else $error("lookahead count above capacity");

  // a compare always follows its read
  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> $past(state_q) == ST_READ)
    else $error("compare without preceding read");

  // the final token of a text leaves the block idle with empty lookahead
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && emit_go && flush_q && la_left == '0)
    |=> (state_q == ST_IDLE && la_cnt_q == '0 && fill_q == '0 && out_last_q))
    else $error("flush did not end cleanly");

  // a token is only loaded when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q == ST_EMIT) |=> state_q == ST_EMIT)
    else $error("token emitted over a stalled one");

endmodule

### sim/lz77_token_encoder_top_test.sv
// lz77_token_encoder_top_test: self-checking testbench of the lz77 token encoder
// depends on lz77te_pkg and lz77_token_encoder_top; random texts over several
// window sizes are checked token by token against a greedy match predictor
`timescale 1ns / 1ps

module lz77_token_encoder_top_test;
  import lz77te_pkg::*;

  localparam int HIST      = DEF_HISTORY_DEPTH;
  localparam int RING      = DEF_RING_DEPTH;
  localparam int MAX_CYCLE = 5000000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eod;
  } byte_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] lit;
    logic              nie;
    logic              last;
  } token_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic              end_of_data_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DIST_W-1:0] match_distance_o;
  logic [LEN_W-1:0]  match_length_o;
  logic [BYTE_W-1:0] literal_byte_o;
  logic              next_is_end_o;
  logic              last_token_o;

  lz77_token_encoder_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .data_byte_i, .end_of_data_i, .out_valid_o, .out_ready_i,
    .match_distance_o, .match_length_o, .literal_byte_o, .next_is_end_o,
    .last_token_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  byte_item_t pending_bytes[$];
  token_t     expected_tokens[$];
  int         error_count = 0;
  int         cycle_count = 0;

  // predictor state
  logic [BYTE_W-1:0] hist_ring[RING];
  int unsigned       cur_pos = 0;
  int unsigned       wr_pos = 0;
  int unsigned       hist_fill = 0;
  int unsigned       la_count = 0;
  int unsigned       window_size = 512;

  function automatic int unsigned ring_idx(int unsigned base, int unsigned back,
                                           int unsigned fwd);
    return (base + RING - back + fwd) % RING;
  endfunction

  function automatic void queue_byte(input byte_item_t it);
    pending_bytes.insert(pending_bytes.size(), it);
  endfunction

  task automatic search_token(input bit last);
    int unsigned win, span, cap, best_len, best_dist, len, used;
    token_t      tok;
    bit          at_end;
    win = (window_size > HIST) ? HIST : window_size;
    span = (win < hist_fill) ? win : hist_fill;
    cap = (la_count < MAX_MATCH) ? la_count : MAX_MATCH;
    best_len = 0;
    best_dist = 0;
    for (int unsigned d = 1; d <= span; d++) begin
      len = 0;
      while (len < cap &&
             hist_ring[ring_idx(cur_pos, d, len)] == hist_ring[ring_idx(cur_pos, 0, len)])
        len++;
      if (len > best_len) begin
        best_len = len;
        best_dist = d;
      end
    end
    at_end = best_len >= la_count;
    tok.distance = DIST_W'(best_dist);
    tok.len = LEN_W'(best_len);
    tok.lit = at_end ? '0 : hist_ring[ring_idx(cur_pos, 0, best_len)];
    tok.nie = at_end;
    tok.last = last;
    expected_tokens.insert(expected_tokens.size(), tok);
    used = at_end ? la_count : best_len + 1;
    cur_pos = ring_idx(cur_pos, 0, used);
    la_count -= used;
    hist_fill += used;
    if (hist_fill > HIST) hist_fill = HIST;
  endtask

  task automatic predict_byte(input byte_item_t it);
    hist_ring[wr_pos] = it.data;
    wr_pos = (wr_pos + 1) % RING;
    la_count++;
    if (it.eod) begin
      while (la_count > 0) search_token(la_count <= 1 ||
                                        1'b0);
      // mark the final flushed token
      expected_tokens[$].last = 1'b1;
      la_count = 0;
      hist_fill = 0;
      cur_pos = wr_pos;
    end else if (la_count >= MAX_MATCH + 1) begin
      search_token(1'b0);
    end
  endtask

  // sender
  int  send_gap = 0;
  bit  burst_mode = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_byte({data_byte_i, end_of_data_i});
      if (in_valid_i && !in_ready_o) begin
        in_valid_i <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        byte_item_t it;
        it = pending_bytes.pop_front();
        data_byte_i <= it.data;
        end_of_data_i <= it.eod;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
        send_gap <= burst_mode ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold
  bit hold_req = 1'b0;
  int long_hold = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold <= 0;
    end else if (hold_req) begin
      long_hold <= 3000;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // receiver and checker
  int recv_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token transfer");
          error_count++;
        end else begin
          token_t e;
          e = expected_tokens.pop_front();
          if (match_distance_o !== e.distance) begin
            $error("match_distance expected %0d got %0d", e.distance, match_distance_o);
            error_count++;
          end
          if (match_length_o !== e.len) begin
            $error("match_length expected %0d got %0d", e.len, match_length_o);
            error_count++;
          end
          if (literal_byte_o !== e.lit) begin
            $error("literal_byte expected %0d got %0d", e.lit, literal_byte_o);
            error_count++;
          end
          if (next_is_end_o !== e.nie) begin
            $error("next_is_end expected %0d got %0d", e.nie, next_is_end_o);
            error_count++;
          end
          if (last_token_o !== e.last) begin
            $error("last_token expected %0d got %0d", e.last, last_token_o);
            error_count++;
          end
        end
        recv_gap <= burst_mode ? 0 : $urandom_range(0, 17);
      end
      if (long_hold > 0) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0 && !(out_valid_o && out_ready_i)) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(out_valid_o && out_ready_i) || burst_mode;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_bytes.size() > 0 || in_valid_i || expected_tokens.size() > 0)
      @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_window(input int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_size = value & 10'h3FF;
  endtask

  task automatic push_text(input int unsigned len, input int unsigned mode);
    byte_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: it.data = BYTE_W'($urandom);
        1: it.data = $urandom_range(0, 1) ? 8'h61 : 8'h62;
        default: it.data = BYTE_W'(8'h30 + (i % (mode + 1)));
      endcase
      if ($urandom_range(0, 9) == 0) it.data = ~it.data;
      it.eod = (i == len - 1);
      queue_byte(it);
    end
  endtask

  int random_sent = 0;

  initial begin
    int unsigned len, win;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default window
    queue_byte({8'h00, 1'b1});
    queue_byte({8'hFF, 1'b1});
    for (int i = 0; i < 20; i++) queue_byte({8'h41, i == 19});
    wait_drained();

    write_window(0);
    queue_byte({8'hAA, 1'b0});
    queue_byte({8'hAA, 1'b0});
    queue_byte({8'h55, 1'b1});
    wait_drained();

    write_window(1023);
    push_text(18, 2);
    wait_drained();

    write_window(1);
    push_text(17, 1);
    wait_drained();

    // receiver held off while the sender keeps offering bytes
    write_window(512);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    push_text(30, 3);
    wait_drained();

    // random texts
    while (random_sent < 50) begin
      case ($urandom_range(0, 6))
        0: win = 0;
        1: win = 1;
        2: win = 512;
        3: win = 1023;
        4: win = 16;
        default: win = $urandom_range(0, 1023);
      endcase
      write_window(win);
      for (int t = 0; t < 3; t++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 30);
        push_text(len, $urandom_range(0, 4));
        random_sent += len;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
